// ===== hdl/strict_priority_multi_queue_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the strict-priority multi-queue.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SPMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An overlapping implication checked at every clock edge outside reset.
`define SPMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication checked at every clock edge outside reset.
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spmq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmq_pkg
// Shared constants, types and helpers of the strict-priority multi-queue.
// ---------------------------------------------------------------------------
package spmq_pkg;

  localparam int PRIORITY_LEVELS = 8;
  localparam int CELL_COUNT      = 256;

  localparam int LEVEL_TOTAL   = PRIORITY_LEVELS + 1;
  localparam int LVL_W         = $clog2(LEVEL_TOTAL);
  localparam int CELL_W        = $clog2(CELL_COUNT);
  localparam int CNT_W         = $clog2(CELL_COUNT + 1);
  localparam int LEVEL_FIELD_W = 4;
  localparam int PAYLOAD_W     = 32;

  typedef logic [LVL_W-1:0]       lvl_t;
  typedef logic [CELL_W-1:0]      cell_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEVEL_TOTAL-1:0] lvl_vec_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Update of the per-level head/tail table.
  typedef struct packed {
    logic  head_we;
    logic  tail_we;
    logic  set_ne;
    logic  clr_ne;
    lvl_t  lvl;
    cell_t head;
    cell_t tail;
  } lvl_wr_t;

  // Levels above the general queue fold onto the general queue.
  function automatic lvl_t sat_level(input logic [LEVEL_FIELD_W-1:0] l);
    if (int'(l) > PRIORITY_LEVELS) begin
      return lvl_t'(PRIORITY_LEVELS);
    end
    return lvl_t'(l);
  endfunction

endpackage

// ===== hdl/spmq_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmq request and response channels
// Valid/ready channels carrying queue requests and their results.
// ---------------------------------------------------------------------------
interface spmq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic [spmq_pkg::LEVEL_FIELD_W-1:0]     level;
  logic [spmq_pkg::PAYLOAD_W-1:0]         payload;

  modport source (output valid, mode, level, payload, input ready);
  modport sink   (input valid, mode, level, payload, output ready);
endinterface

interface spmq_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   accepted;
  logic                                   store_full;
  logic                                   queue_empty;
  logic [spmq_pkg::PAYLOAD_W-1:0]         served_payload;
  logic [spmq_pkg::LEVEL_FIELD_W-1:0]     served_level;

  modport source (output valid, accepted, store_full, queue_empty, served_payload,
                  served_level, input ready);
  modport sink   (input valid, accepted, store_full, queue_empty, served_payload,
                  served_level, output ready);
endinterface

// ===== hdl/strict_priority_multi_queue.sv =====
`timescale 1ns / 1ps
// A request accepted from idle is captured, then executed in ST_EXEC, which writes its result into the output register.
// Requests do not overlap: the cell memories are read in the accept cycle and written back in the
// next, and the next request waits for that write-back and for room in the result register.
// Reset: all levels empty and every cell free, effective at once; no clearing pass is needed
// because untouched cells are handed out by a fresh-cell counter.
// ---------------------------------------------------------------------------
// strict_priority_multi_queue
// Strict-priority multi-level FIFO over a shared pool of linked cells.
// ---------------------------------------------------------------------------
module strict_priority_multi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  spmq_req_if.sink       req_i,
  spmq_rsp_if.source     rsp_o
);

  `include "strict_priority_multi_queue_assert.svh"

  // -------------------------------------------------------------------------
  // Storage overview.
  // Two RAMs hold the cells: one with the stored payload words and one with
  // the link to the next cell. The link RAM serves both the per-level FIFO
  // chains and the free list. Per-level head/tail pointers and occupancy
  // bits live in the level table.
  //
  // The free list starts as the chain 0, 1, 2, ... of never-used cells. A
  // counter (fresh_q) marks how many cells have ever been handed out. The
  // free-list head equals fresh_q exactly when it points at an untouched
  // cell, and then its successor is simply the next index, so the link RAM
  // needs no initialization. Released cells are pushed at the front of the
  // free list and their links are written into the link RAM.
  // -------------------------------------------------------------------------

  spmq_pkg::state_e  state_q, state_d;

  // Request captured in the accept cycle.
  logic                                 op_mode_q;
  spmq_pkg::lvl_t                       op_lvl_q;
  logic [spmq_pkg::PAYLOAD_W-1:0]       op_payload_q;
  logic                                 op_found_q;
  spmq_pkg::cell_t                      op_cell_q;

  // Free-list bookkeeping.
  spmq_pkg::cell_t   free_head_q, free_head_d;
  spmq_pkg::cnt_t    free_count_q, free_count_d;
  spmq_pkg::cnt_t    fresh_q, fresh_d;

  // Result register.
  logic                                 rsp_valid_q, rsp_valid_d;
  logic                                 rsp_acc_q, rsp_acc_d;
  logic                                 rsp_full_q, rsp_full_d;
  logic                                 rsp_empty_q, rsp_empty_d;
  logic [spmq_pkg::PAYLOAD_W-1:0]       rsp_pay_q, rsp_pay_d;
  logic [spmq_pkg::LEVEL_FIELD_W-1:0]   rsp_lvl_q, rsp_lvl_d;

  // Level table connections.
  spmq_pkg::lvl_wr_t   lvl_wr;
  spmq_pkg::lvl_t      rd_lvl;
  spmq_pkg::cell_t     lvl_head;
  spmq_pkg::cell_t     lvl_tail;
  spmq_pkg::lvl_vec_t  lvl_ne;
  spmq_pkg::lvl_t      low_lvl;
  logic                low_found;

  // RAM connections.
  logic                                 pay_we;
  logic [spmq_pkg::PAYLOAD_W-1:0]       pay_rdata;
  logic                                 nxt_we;
  spmq_pkg::cell_t                      nxt_waddr;
  spmq_pkg::cell_t                      nxt_wdata;
  spmq_pkg::cell_t                      nxt_raddr;
  spmq_pkg::cell_t                      nxt_rdata;

  logic req_fire;
  logic is_deq;
  logic fresh_pop;

  // A request is taken only from idle, and only when the result register
  // will be empty by the time this request's result is written.
  assign req_i.ready = (state_q == spmq_pkg::ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_deq      = (req_i.mode == spmq_pkg::MODE_DEQ);

  // In the accept cycle the table is looked up at the most urgent occupied
  // level (for a dequeue); during execution at the captured level.
  assign rd_lvl = (state_q == spmq_pkg::ST_IDLE) ? low_lvl : op_lvl_q;

  // Link RAM read: successor of the free-list head for an enqueue, successor
  // of the served head cell for a dequeue. Data arrives in the next cycle.
  assign nxt_raddr = is_deq ? lvl_head : free_head_q;

  // The free-list head is an untouched cell when it equals the fresh mark.
  assign fresh_pop = (fresh_q != spmq_pkg::cnt_t'(spmq_pkg::CELL_COUNT)) &&
                     (op_cell_q == fresh_q[spmq_pkg::CELL_W-1:0]);

  spmq_level_table u_level_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (lvl_wr),
    .rd_lvl_i   (rd_lvl),
    .head_o     (lvl_head),
    .tail_o     (lvl_tail),
    .nonempty_o (lvl_ne),
    .low_lvl_o  (low_lvl),
    .found_o    (low_found)
  );

  spmq_ram #(
    .WIDTH (spmq_pkg::PAYLOAD_W),
    .DEPTH (spmq_pkg::CELL_COUNT)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (op_cell_q),
    .wdata_i (op_payload_q),
    .raddr_i (lvl_head),
    .rdata_o (pay_rdata)
  );

  spmq_ram #(
    .WIDTH (spmq_pkg::CELL_W),
    .DEPTH (spmq_pkg::CELL_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  // Capture of the request in the accept cycle. For a dequeue the served
  // level and cell are fixed here; for an enqueue the cell is the current
  // free-list head.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_mode_q    <= req_i.mode;
      op_lvl_q     <= is_deq ? low_lvl : spmq_pkg::sat_level(req_i.level);
      op_payload_q <= req_i.payload;
      op_found_q   <= low_found;
      op_cell_q    <= is_deq ? lvl_head : free_head_q;
    end
  end

  // Sequencer: the accept cycle reads, the execute cycle modifies and writes
  // back. Nothing in the table or the RAMs changes during the accept cycle,
  // so no forwarding is needed between consecutive requests.
  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    fresh_d      = fresh_q;
    lvl_wr       = '0;
    lvl_wr.lvl   = op_lvl_q;
    pay_we       = 1'b0;
    nxt_we       = 1'b0;
    nxt_waddr    = lvl_tail;
    nxt_wdata    = op_cell_q;

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_acc_d    = rsp_acc_q;
    rsp_full_d   = rsp_full_q;
    rsp_empty_d  = rsp_empty_q;
    rsp_pay_d    = rsp_pay_q;
    rsp_lvl_d    = rsp_lvl_q;

    unique case (state_q)
      spmq_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = spmq_pkg::ST_EXEC;
        end
      end
      spmq_pkg::ST_EXEC: begin
        state_d     = spmq_pkg::ST_IDLE;
        rsp_valid_d = 1'b1;
        rsp_acc_d   = 1'b0;
        rsp_full_d  = 1'b0;
        rsp_empty_d = 1'b0;
        rsp_pay_d   = '0;
        rsp_lvl_d   = '0;
        if (op_mode_q == spmq_pkg::MODE_ENQ) begin
          if (free_count_q == '0) begin
            rsp_full_d = 1'b1;
          end else begin
            // Pop the free list and append the cell to its level.
            rsp_acc_d    = 1'b1;
            free_count_d = free_count_q - spmq_pkg::cnt_t'(1);
            if (fresh_pop) begin
              free_head_d = op_cell_q + spmq_pkg::cell_t'(1);
              fresh_d     = fresh_q + spmq_pkg::cnt_t'(1);
            end else begin
              free_head_d = nxt_rdata;
            end
            pay_we = 1'b1;
            if (lvl_ne[op_lvl_q]) begin
              // Link the old tail to the new cell.
              nxt_we    = 1'b1;
              nxt_waddr = lvl_tail;
              nxt_wdata = op_cell_q;
            end else begin
              lvl_wr.head_we = 1'b1;
              lvl_wr.head    = op_cell_q;
            end
            lvl_wr.tail_we = 1'b1;
            lvl_wr.tail    = op_cell_q;
            lvl_wr.set_ne  = 1'b1;
          end
        end else begin
          if (!op_found_q) begin
            rsp_empty_d = 1'b1;
          end else begin
            rsp_acc_d = 1'b1;
            rsp_pay_d = pay_rdata;
            rsp_lvl_d = spmq_pkg::LEVEL_FIELD_W'(op_lvl_q);
            // The last entry of a level empties it; otherwise the head moves on.
            if (op_cell_q == lvl_tail) begin
              lvl_wr.clr_ne = 1'b1;
            end else begin
              lvl_wr.head_we = 1'b1;
              lvl_wr.head    = nxt_rdata;
            end
            // Push the served cell at the front of the free list.
            nxt_we       = 1'b1;
            nxt_waddr    = op_cell_q;
            nxt_wdata    = free_head_q;
            free_head_d  = op_cell_q;
            free_count_d = free_count_q + spmq_pkg::cnt_t'(1);
          end
        end
      end
      default: begin
        state_d = spmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spmq_pkg::ST_IDLE;
      free_head_q  <= '0;
      free_count_q <= spmq_pkg::cnt_t'(spmq_pkg::CELL_COUNT);
      fresh_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      fresh_q      <= fresh_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_acc_q   <= rsp_acc_d;
    rsp_full_q  <= rsp_full_d;
    rsp_empty_q <= rsp_empty_d;
    rsp_pay_q   <= rsp_pay_d;
    rsp_lvl_q   <= rsp_lvl_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.accepted       = rsp_acc_q;
  assign rsp_o.store_full     = rsp_full_q;
  assign rsp_o.queue_empty    = rsp_empty_q;
  assign rsp_o.served_payload = rsp_pay_q;
  assign rsp_o.served_level   = rsp_lvl_q;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `SPMQ_ASSERT(a_free_count_range,
    free_count_q <= spmq_pkg::cnt_t'(spmq_pkg::CELL_COUNT), "free count above pool size")
  `SPMQ_ASSERT(a_fresh_range,
    fresh_q <= spmq_pkg::cnt_t'(spmq_pkg::CELL_COUNT), "fresh mark above pool size")
  `SPMQ_ASSERT_IMP(a_all_free_all_empty,
    free_count_q == spmq_pkg::cnt_t'(spmq_pkg::CELL_COUNT), lvl_ne == '0,
    "a level holds entries while every cell is free")
  `SPMQ_ASSERT_IMP(a_one_outcome, rsp_valid_q,
    $onehot({rsp_acc_q, rsp_full_q, rsp_empty_q}), "result carries no single outcome")
  `SPMQ_ASSERT_NEXT(a_accept_executes, req_fire,
    state_q == spmq_pkg::ST_EXEC && !rsp_valid_q, "accepted request did not execute")

endmodule

// ===== hdl/spmq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spmq_level_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmq_level_table
// Head, tail and occupancy of every level, with the most-urgent-level pick.
// ---------------------------------------------------------------------------
module spmq_level_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spmq_pkg::lvl_wr_t          wr_i,
  input  spmq_pkg::lvl_t             rd_lvl_i,
  output spmq_pkg::cell_t            head_o,
  output spmq_pkg::cell_t            tail_o,
  output spmq_pkg::lvl_vec_t         nonempty_o,
  output spmq_pkg::lvl_t             low_lvl_o,
  output logic                       found_o
);

  spmq_pkg::cell_t    head_q [spmq_pkg::LEVEL_TOTAL];
  spmq_pkg::cell_t    tail_q [spmq_pkg::LEVEL_TOTAL];
  spmq_pkg::lvl_vec_t ne_q;
  spmq_pkg::lvl_vec_t ne_d;

  // Head and tail pointers are only meaningful while the level is occupied.
  always_ff @(posedge clk_i) begin
    if (wr_i.head_we) begin
      head_q[wr_i.lvl] <= wr_i.head;
    end
    if (wr_i.tail_we) begin
      tail_q[wr_i.lvl] <= wr_i.tail;
    end
  end

  always_comb begin
    ne_d = ne_q;
    if (wr_i.set_ne) begin
      ne_d[wr_i.lvl] = 1'b1;
    end
    if (wr_i.clr_ne) begin
      ne_d[wr_i.lvl] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else begin
      ne_q <= ne_d;
    end
  end

  // Lowest occupied level wins.
  always_comb begin
    low_lvl_o = '0;
    found_o   = 1'b0;
    for (int i = spmq_pkg::LEVEL_TOTAL - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        low_lvl_o = spmq_pkg::lvl_t'(i);
        found_o   = 1'b1;
      end
    end
  end

  assign head_o     = head_q[rd_lvl_i];
  assign tail_o     = tail_q[rd_lvl_i];
  assign nonempty_o = ne_q;

endmodule
